@@ design/pgoc_pkg.sv @@
// Shared types, constants and helper functions of the gray overlay compositor.
`timescale 1ns / 1ps

package pgoc_pkg;

  localparam int DimW    = 13;
  localparam int PosW    = 12;
  localparam int ChanW   = 8;
  localparam int CoordW  = 15;
  localparam int RegIdxW = 3;
  localparam int ProdW   = 24;

  localparam int FrameThickness = 10;
  localparam int FrameSpanX     = 200;
  localparam int FrameSpanY     = 270;
  localparam int MaxDim         = 4096;

  // Luma weights over 65536; they sum to exactly 65536.
  localparam logic [15:0] WeightRed   = 16'd13933;
  localparam logic [15:0] WeightGreen = 16'd46871;
  localparam logic [15:0] WeightBlue  = 16'd4732;

  localparam logic [ChanW-1:0] ChanFull = 8'hFF;
  localparam logic [ChanW-1:0] ChanZero = 8'h00;

  localparam logic [DimW-1:0] ResetImageWidth  = 13'd1024;
  localparam logic [DimW-1:0] ResetImageHeight = 13'd1536;
  localparam logic [DimW-1:0] ResetCornerWidth = 13'd128;
  localparam logic [DimW-1:0] ResetCornerHeight = 13'd128;
  localparam logic [DimW-1:0] ResetCenterWidth = 13'd256;
  localparam logic [DimW-1:0] ResetCenterHeight = 13'd256;
  localparam logic [PosW-1:0] ResetFrameLeft   = 12'd446;
  localparam logic [PosW-1:0] ResetFrameTop    = 12'd951;

  typedef enum logic [RegIdxW-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_CORNER_WIDTH,
    REG_CORNER_HEIGHT,
    REG_CENTER_WIDTH,
    REG_CENTER_HEIGHT,
    REG_FRAME_LEFT,
    REG_FRAME_TOP
  } reg_idx_t;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic [DimW-1:0] corner_logo_width;
    logic [DimW-1:0] corner_logo_height;
    logic [DimW-1:0] center_logo_width;
    logic [DimW-1:0] center_logo_height;
    logic [PosW-1:0] frame_left;
    logic [PosW-1:0] frame_top;
  } cfg_t;

  typedef struct packed {
    logic corner_hit;
    logic center_hit;
    logic edge_black;
    logic edge_red;
    logic frame_hit;
  } overlay_flags_t;

  // A size register above the largest supported dimension counts as that dimension.
  function automatic coord_t dim_coord(logic [DimW-1:0] v);
    logic [DimW-1:0] c;
    c = v;
    if (int'(v) > MaxDim) begin
      c = DimW'(MaxDim);
    end
    return coord_t'({2'b00, c});
  endfunction

  function automatic coord_t pos_coord(logic [PosW-1:0] v);
    return coord_t'({3'b000, v});
  endfunction

  function automatic logic in_span(coord_t v, coord_t lo, coord_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

@@ design/pgoc_regions.sv @@
// Region decode: logo, border and frame hit flags for one pixel position.
`timescale 1ns / 1ps

module pgoc_regions (
  input  pgoc_pkg::cfg_t                  cfg,
  input  logic [pgoc_pkg::PosW-1:0]       pixel_row,
  input  logic [pgoc_pkg::PosW-1:0]       pixel_col,
  input  logic [pgoc_pkg::ChanW-1:0]      corner_red,
  input  logic [pgoc_pkg::ChanW-1:0]      corner_green,
  input  logic [pgoc_pkg::ChanW-1:0]      corner_blue,
  input  logic [pgoc_pkg::ChanW-1:0]      center_red,
  input  logic [pgoc_pkg::ChanW-1:0]      center_green,
  input  logic [pgoc_pkg::ChanW-1:0]      center_blue,
  output pgoc_pkg::overlay_flags_t        flags
);
  import pgoc_pkg::*;

  coord_t w, h, cw, ch, zw, zh;
  coord_t r, c;
  coord_t cy, cx;
  coord_t fl, ft, fr, fb, t;
  logic   in_image;
  logic   corner_key_ok, center_key_ok;

  always_comb begin
    w  = dim_coord(cfg.image_width);
    h  = dim_coord(cfg.image_height);
    cw = dim_coord(cfg.corner_logo_width);
    ch = dim_coord(cfg.corner_logo_height);
    zw = dim_coord(cfg.center_logo_width);
    zh = dim_coord(cfg.center_logo_height);
    r  = pos_coord(pixel_row);
    c  = pos_coord(pixel_col);

    in_image = (r < h) && (c < w);

    // The key test passes only when no channel of the logo is full scale.
    corner_key_ok = (corner_red != ChanFull) && (corner_green != ChanFull) &&
                    (corner_blue != ChanFull);
    center_key_ok = (center_red != ChanFull) && (center_green != ChanFull) &&
                    (center_blue != ChanFull);

    flags.corner_hit = in_image && (r >= h - ch) && (c >= w - cw) && corner_key_ok;

    // Dimensions are never negative, so the arithmetic shift is a truncating half.
    cy = (h >>> 1) - (zh >>> 1);
    cx = (w >>> 1) - (zw >>> 1);
    flags.center_hit = in_image && (r >= cy) && (r < cy + zh) &&
                       (c >= cx) && (c < cx + zw) && center_key_ok;

    flags.edge_black = in_image && ((c == '0) || (r == '0));
    flags.edge_red   = in_image && ((c == w - coord_t'(1)) || (r == h - coord_t'(1)));

    fl = pos_coord(cfg.frame_left);
    ft = pos_coord(cfg.frame_top);
    fr = fl + coord_t'(FrameSpanX);
    fb = ft + coord_t'(FrameSpanY);
    t  = coord_t'(FrameThickness);
    flags.frame_hit =
      (in_span(r, ft, fb) &&
       (in_span(c, fl, fl + t - coord_t'(1)) || in_span(c, fr - t + coord_t'(1), fr))) ||
      (in_span(c, fl, fr) &&
       (in_span(r, ft, ft + t - coord_t'(1)) || in_span(r, fb - t + coord_t'(1), fb)));
  end

endmodule

@@ design/pixel_gray_overlay_compositor.sv @@
// Top level of the gray overlay compositor: input stage, gray products and compositing.
//
//   channel   handshake         payload
//   pixel in  start / busy      pixel_row, pixel_col, main_*, corner_*, center_*
//   pixel out done (strobe)     out_red, out_green, out_blue
//   config    wr_en             wr_index, wr_data
//
// One pixel beat is taken in every cycle; busy is held low, as nothing in the
// datapath iterates. A result passes the input and product registers into the output
// register and is marked by done for one cycle; the receiver cannot stall. The three
// stages are the input register, the weighted products with the region flags, and the
// final sum and select into the output register. Reset is synchronous, clears the
// stage valid bits and returns the register file to its reset values.
`timescale 1ns / 1ps

module pixel_gray_overlay_compositor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [pgoc_pkg::PosW-1:0]       pixel_row,
  input  logic [pgoc_pkg::PosW-1:0]       pixel_col,
  input  logic [pgoc_pkg::ChanW-1:0]      main_red,
  input  logic [pgoc_pkg::ChanW-1:0]      main_green,
  input  logic [pgoc_pkg::ChanW-1:0]      main_blue,
  input  logic [pgoc_pkg::ChanW-1:0]      corner_red,
  input  logic [pgoc_pkg::ChanW-1:0]      corner_green,
  input  logic [pgoc_pkg::ChanW-1:0]      corner_blue,
  input  logic [pgoc_pkg::ChanW-1:0]      center_red,
  input  logic [pgoc_pkg::ChanW-1:0]      center_green,
  input  logic [pgoc_pkg::ChanW-1:0]      center_blue,
  output logic                            done,
  output logic [pgoc_pkg::ChanW-1:0]      out_red,
  output logic [pgoc_pkg::ChanW-1:0]      out_green,
  output logic [pgoc_pkg::ChanW-1:0]      out_blue,
  input  logic                            wr_en,
  input  logic [pgoc_pkg::RegIdxW-1:0]    wr_index,
  input  logic [pgoc_pkg::DimW-1:0]       wr_data
);
  import pgoc_pkg::*;

  cfg_t cfg;

  logic             accept;
  logic             s1_valid;
  logic [PosW-1:0]  s1_row, s1_col;
  logic [ChanW-1:0] s1_red, s1_green, s1_blue;
  logic [ChanW-1:0] s1_corner_red, s1_corner_green, s1_corner_blue;
  logic [ChanW-1:0] s1_center_red, s1_center_green, s1_center_blue;

  overlay_flags_t   s1_flags;

  logic             s2_valid;
  logic [ProdW-1:0] s2_prod_red, s2_prod_green, s2_prod_blue;
  overlay_flags_t   s2_flags;
  logic [ChanW-1:0] s2_corner_red, s2_corner_green, s2_corner_blue;

  logic [ProdW-1:0] gray_sum;
  logic [ChanW-1:0] red_next, green_next, blue_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width        <= ResetImageWidth;
      cfg.image_height       <= ResetImageHeight;
      cfg.corner_logo_width  <= ResetCornerWidth;
      cfg.corner_logo_height <= ResetCornerHeight;
      cfg.center_logo_width  <= ResetCenterWidth;
      cfg.center_logo_height <= ResetCenterHeight;
      cfg.frame_left         <= ResetFrameLeft;
      cfg.frame_top          <= ResetFrameTop;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_IMAGE_WIDTH:   cfg.image_width        <= wr_data;
        REG_IMAGE_HEIGHT:  cfg.image_height       <= wr_data;
        REG_CORNER_WIDTH:  cfg.corner_logo_width  <= wr_data;
        REG_CORNER_HEIGHT: cfg.corner_logo_height <= wr_data;
        REG_CENTER_WIDTH:  cfg.center_logo_width  <= wr_data;
        REG_CENTER_HEIGHT: cfg.center_logo_height <= wr_data;
        REG_FRAME_LEFT:    cfg.frame_left         <= wr_data[PosW-1:0];
        REG_FRAME_TOP:     cfg.frame_top          <= wr_data[PosW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_row          <= pixel_row;
      s1_col          <= pixel_col;
      s1_red          <= main_red;
      s1_green        <= main_green;
      s1_blue         <= main_blue;
      s1_corner_red   <= corner_red;
      s1_corner_green <= corner_green;
      s1_corner_blue  <= corner_blue;
      s1_center_red   <= center_red;
      s1_center_green <= center_green;
      s1_center_blue  <= center_blue;
    end
  end

  pgoc_regions u_regions (
    .cfg          (cfg),
    .pixel_row    (s1_row),
    .pixel_col    (s1_col),
    .corner_red   (s1_corner_red),
    .corner_green (s1_corner_green),
    .corner_blue  (s1_corner_blue),
    .center_red   (s1_center_red),
    .center_green (s1_center_green),
    .center_blue  (s1_center_blue),
    .flags        (s1_flags)
  );

  // Product stage: weights are constants, so each product is a short adder tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_prod_red     <= ProdW'(WeightRed) * ProdW'(s1_red);
      s2_prod_green   <= ProdW'(WeightGreen) * ProdW'(s1_green);
      s2_prod_blue    <= ProdW'(WeightBlue) * ProdW'(s1_blue);
      s2_flags        <= s1_flags;
      s2_corner_red   <= s1_corner_red;
      s2_corner_green <= s1_corner_green;
      s2_corner_blue  <= s1_corner_blue;
    end
  end

  // The weights sum to 65536, so the total never exceeds 24 bits.
  assign gray_sum = s2_prod_red + s2_prod_green + s2_prod_blue;

  always_comb begin
    red_next   = gray_sum[ProdW-1:ProdW-ChanW];
    green_next = gray_sum[ProdW-1:ProdW-ChanW];
    blue_next  = gray_sum[ProdW-1:ProdW-ChanW];
    if (s2_flags.corner_hit) begin
      red_next   = s2_corner_red;
      green_next = s2_corner_green;
      blue_next  = s2_corner_blue;
    end
    if (s2_flags.center_hit) begin
      red_next  = ChanFull;
      blue_next = ChanFull;
    end
    if (s2_flags.edge_black) begin
      red_next   = ChanZero;
      green_next = ChanZero;
      blue_next  = ChanZero;
    end
    if (s2_flags.edge_red) begin
      red_next = ChanZero;
    end
    if (s2_flags.frame_hit) begin
      red_next   = ChanFull;
      green_next = ChanFull;
      blue_next  = ChanFull;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    if (s2_valid) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
    end
  end

  // A result beat always traces back to an accepted input beat.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result beat without a matching input beat");

  // The frame overrides every earlier step.
  a_frame_white: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_flags.frame_hit) |=>
      (out_red == ChanFull && out_green == ChanFull && out_blue == ChanFull))
    else $error("frame pixel is not white");

  // Left and top border pixels outside the frame come out black.
  a_edge_black: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_flags.edge_black && !s2_flags.frame_hit) |=>
      (out_red == ChanZero && out_green == ChanZero && out_blue == ChanZero))
    else $error("border pixel is not black");

endmodule
